// File: src/grouped_timer_queue_manager_unit_macros.svh
// assertion shorthands used by the block's controller module
// both expect signals named clk and rst in the scope of use
`ifndef GROUPED_TIMER_QUEUE_MANAGER_UNIT_MACROS_SVH
`define GROUPED_TIMER_QUEUE_MANAGER_UNIT_MACROS_SVH

// same-cycle implication
`define GTQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtq: property violated");

// next-cycle implication
`define GTQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtq: property violated");

`endif

// File: src/gtq_pkg.sv
package gtq_pkg;

  // opcodes
  localparam logic [1:0] OP_ATTACH   = 2'd0;
  localparam logic [1:0] OP_REATTACH = 2'd1;
  localparam logic [1:0] OP_DETACH   = 2'd2;
  localparam logic [1:0] OP_CHECK    = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SLOT    = 3'd1;
  localparam logic [2:0] ST_GROUP_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_ID     = 3'd3;
  localparam logic [2:0] ST_NOT_USED   = 3'd4;

  localparam logic [5:0] MAX_FIRE = 6'd63;
  localparam int EXP_W = 49;
  localparam int TO_W  = 31;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] now;
    logic [30:0] timeout;
    logic [5:0]  timer_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot_out;
    logic       fired;
    logic [5:0] fire_count;
    logic       last;
  } rsp_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } push_t;

endpackage

// File: src/gtq_ram.sv
module gtq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                       wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                       rdata
);
  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/gtq_ctrl.sv
`include "grouped_timer_queue_manager_unit_macros.svh"
module gtq_ctrl #(
  parameter int TIMER_SLOTS    = 64,
  parameter int TIMEOUT_GROUPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  gtq_pkg::cmd_t  cmd,
  output logic           busy,
  input  logic           can_push,
  output gtq_pkg::push_t push
);
  import gtq_pkg::*;

  localparam int SW  = $clog2(TIMER_SLOTS);
  localparam int GIW = (TIMEOUT_GROUPS > 1) ? $clog2(TIMEOUT_GROUPS) : 1;
  localparam int GW  = $clog2(TIMEOUT_GROUPS + 1);
  localparam logic [GW-1:0] NO_GRP = GW'(TIMEOUT_GROUPS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TIMER_SLOTS - 1);

  typedef enum logic [4:0] {
    IDLE, A_POP, UNQ, REL, ENQ, F_WALK, F_NEW, F_LINK, APPEND, APP2, RESULT,
    C_GRP, C_HEAD, C_EXP, C_EMIT, D_START, D_GRP, D_CHK, C_FIN
  } state_t;

  state_t state;
  logic [1:0]  op_q;
  logic [47:0] now_q;
  logic [TO_W-1:0] to_q;
  logic [5:0]  id_q;
  logic [SW-1:0] s, t, free_head, sraddr_q;
  logic [GW-1:0] g, gn, lk, pg, ends0, ends1;
  logic [5:0]  cnt;
  logic [TIMER_SLOTS-1:0] in_use, queued, nxt_ok;
  logic [TIMEOUT_GROUPS-1:0] gvalid;
  logic pend_valid;
  rsp_t pend, res;

  // memory ports
  logic [SW-1:0] s_raddr;
  logic [GIW-1:0] g_raddr;
  logic nxt_we, prv_we, exp_we, sg_we, hd_we, tl_we, to_we, on_we;
  logic [SW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, hd_wd, tl_wd;
  logic [GIW-1:0] hd_wa, tl_wa, to_wa, on_wa;
  logic [GW-1:0] on_wd;
  logic [EXP_W-1:0] exp_wd, exp_rd;
  logic [SW-1:0] nram_rd, next_rd, prev_rd, head_rd, tail_rd;
  logic [GIW-1:0] sg_rd;
  logic [TO_W-1:0] to_rd;
  logic [GW-1:0] onext_rd;

  logic [SW-1:0] idx;
  logic id_bad, expired, do_unq;
  logic [GIW-1:0] fg;
  logic fg_found;

  assign idx    = SW'(cmd.timer_id);
  assign id_bad = (cmd.timer_id == 6'd0) || (int'(cmd.timer_id) >= TIMER_SLOTS);
  assign busy   = (state != IDLE);

  // unwritten next links read as the reset free chain
  assign next_rd = nxt_ok[sraddr_q] ? nram_rd :
                   ((sraddr_q == LAST_SLOT) ? '0 : sraddr_q + SW'(1));

  assign expired = exp_rd <= EXP_W'(now_q);
  assign do_unq  = queued[s] && ((state == UNQ) || (state == C_EXP && expired));

  // lowest free group
  always_comb begin
    fg = '0;
    fg_found = 1'b0;
    for (int i = TIMEOUT_GROUPS - 1; i >= 0; i--) begin
      if (!gvalid[i]) begin
        fg = GIW'(i);
        fg_found = 1'b1;
      end
    end
  end

  // read addresses
  always_comb begin
    s_raddr = s;
    g_raddr = g[GIW-1:0];
    case (state)
      IDLE:    s_raddr = (cmd.opcode == OP_ATTACH) ? free_head : idx;
      C_HEAD:  s_raddr = head_rd;
      ENQ:     g_raddr = ends0[GIW-1:0];
      F_WALK:  g_raddr = onext_rd[GIW-1:0];
      default: ;
    endcase
  end

  // write ports
  always_comb begin
    nxt_we = 1'b0; nxt_wa = s; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = s; prv_wd = t;
    exp_we = 1'b0; exp_wd = EXP_W'(now_q) + EXP_W'(to_q);
    sg_we  = 1'b0;
    hd_we  = 1'b0; hd_wa = g[GIW-1:0]; hd_wd = s;
    tl_we  = 1'b0; tl_wa = g[GIW-1:0]; tl_wd = s;
    to_we  = 1'b0; to_wa = fg;
    on_we  = 1'b0; on_wa = fg; on_wd = NO_GRP;
    if (do_unq) begin
      // unlink from the group queue
      if (prev_rd != '0) begin
        nxt_we = 1'b1; nxt_wa = prev_rd; nxt_wd = next_rd;
      end else begin
        hd_we = 1'b1; hd_wa = sg_rd; hd_wd = next_rd;
      end
      if (next_rd != '0) begin
        prv_we = 1'b1; prv_wa = next_rd; prv_wd = prev_rd;
      end else begin
        tl_we = 1'b1; tl_wa = sg_rd; tl_wd = prev_rd;
      end
    end
    case (state)
      REL: begin
        nxt_we = in_use[s]; nxt_wa = s; nxt_wd = free_head;
      end
      ENQ: exp_we = 1'b1;
      F_NEW: begin
        to_we = fg_found;
        on_we = fg_found;
      end
      F_LINK: begin
        on_we = 1'b1; on_wa = lk[GIW-1:0]; on_wd = g;
      end
      APPEND: begin
        nxt_we = 1'b1; nxt_wa = s; nxt_wd = '0;
        prv_we = 1'b1; prv_wa = s; prv_wd = t;
        sg_we  = 1'b1;
        tl_we  = 1'b1;
        hd_we  = (t == '0);
      end
      APP2: begin
        nxt_we = 1'b1; nxt_wa = t; nxt_wd = s;
      end
      D_CHK: begin
        on_we = (head_rd == '0) && (pg != NO_GRP);
        on_wa = pg[GIW-1:0]; on_wd = onext_rd;
      end
      default: ;
    endcase
  end

  gtq_ram #(.W(SW), .D(TIMER_SLOTS)) u_next (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(s_raddr), .rdata(nram_rd));
  gtq_ram #(.W(SW), .D(TIMER_SLOTS)) u_prev (
    .clk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(s_raddr), .rdata(prev_rd));
  gtq_ram #(.W(EXP_W), .D(TIMER_SLOTS)) u_exp (
    .clk, .we(exp_we), .waddr(s), .wdata(exp_wd), .raddr(s_raddr), .rdata(exp_rd));
  gtq_ram #(.W(GIW), .D(TIMER_SLOTS)) u_sgrp (
    .clk, .we(sg_we), .waddr(s), .wdata(g[GIW-1:0]), .raddr(s_raddr), .rdata(sg_rd));
  gtq_ram #(.W(SW), .D(TIMEOUT_GROUPS)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(g_raddr), .rdata(head_rd));
  gtq_ram #(.W(SW), .D(TIMEOUT_GROUPS)) u_tail (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(g_raddr), .rdata(tail_rd));
  gtq_ram #(.W(TO_W), .D(TIMEOUT_GROUPS)) u_to (
    .clk, .we(to_we), .waddr(to_wa), .wdata(to_q), .raddr(g_raddr), .rdata(to_rd));
  gtq_ram #(.W(GW), .D(TIMEOUT_GROUPS)) u_onext (
    .clk, .we(on_we), .waddr(on_wa), .wdata(on_wd), .raddr(g_raddr), .rdata(onext_rd));

  // result toward the output register
  always_comb begin
    rsp_t fin;
    fin = pend;
    fin.last = 1'b1;
    push.valid = 1'b0;
    push.rsp = res;
    case (state)
      RESULT: push.valid = can_push;
      C_EMIT: begin
        push.valid = pend_valid && can_push;
        push.rsp = pend;
      end
      C_FIN: begin
        push.valid = can_push;
        push.rsp = pend_valid ? fin :
                   rsp_t'{status: ST_OK, slot_out: '0, fired: 1'b0, fire_count: '0,
                          last: 1'b1};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      free_head  <= SW'(1);
      ends0      <= NO_GRP;
      ends1      <= NO_GRP;
      in_use     <= '0;
      queued     <= '0;
      nxt_ok     <= '0;
      gvalid     <= '0;
      pend_valid <= 1'b0;
    end else begin
      sraddr_q <= s_raddr;
      if (nxt_we) begin
        nxt_ok[nxt_wa] <= 1'b1;
      end
      if (do_unq) begin
        queued[s] <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd_valid) begin
            op_q <= cmd.opcode;
            now_q <= cmd.now;
            to_q <= cmd.timeout;
            id_q <= cmd.timer_id;
            cnt <= '0;
            pend_valid <= 1'b0;
            case (cmd.opcode)
              OP_ATTACH: begin
                if (free_head == '0) begin
                  res <= '{status: ST_NO_SLOT, slot_out: '0, fired: 1'b0,
                           fire_count: '0, last: 1'b1};
                  state <= RESULT;
                end else begin
                  s <= free_head;
                  state <= A_POP;
                end
              end
              OP_CHECK: begin
                g <= ends0;
                state <= C_GRP;
              end
              default: begin
                if (id_bad) begin
                  res <= '{status: ST_BAD_ID, slot_out: cmd.timer_id, fired: 1'b0,
                           fire_count: '0, last: 1'b1};
                  state <= RESULT;
                end else if (cmd.opcode == OP_REATTACH && !in_use[idx]) begin
                  res <= '{status: ST_NOT_USED, slot_out: cmd.timer_id, fired: 1'b0,
                           fire_count: '0, last: 1'b1};
                  state <= RESULT;
                end else begin
                  s <= idx;
                  if (queued[idx]) state <= UNQ;
                  else if (cmd.opcode == OP_DETACH) state <= REL;
                  else state <= ENQ;
                end
              end
            endcase
          end
        end
        A_POP: begin
          free_head <= next_rd;
          in_use[s] <= 1'b1;
          queued[s] <= 1'b0;
          state <= ENQ;
        end
        UNQ: state <= (op_q == OP_DETACH) ? REL : ENQ;
        REL: begin
          if (in_use[s]) begin
            free_head <= s;
            in_use[s] <= 1'b0;
            queued[s] <= 1'b0;
          end
          case (op_q)
            OP_CHECK: state <= C_EMIT;
            OP_DETACH: begin
              res <= '{status: ST_OK, slot_out: id_q, fired: 1'b0,
                       fire_count: '0, last: 1'b1};
              state <= RESULT;
            end
            default: begin
              res <= '{status: ST_GROUP_FULL,
                       slot_out: (op_q == OP_ATTACH) ? 6'd0 : id_q,
                       fired: 1'b0, fire_count: '0, last: 1'b1};
              state <= RESULT;
            end
          endcase
        end
        ENQ: begin
          g <= ends0;
          state <= (ends0 == NO_GRP) ? F_NEW : F_WALK;
        end
        // walk the group order looking for the timeout
        F_WALK: begin
          if (to_rd == to_q) begin
            t <= tail_rd;
            state <= APPEND;
          end else begin
            g <= onext_rd;
            if (onext_rd == NO_GRP) state <= F_NEW;
          end
        end
        F_NEW: begin
          if (!fg_found) begin
            state <= REL;
          end else begin
            g <= GW'(fg);
            gvalid[fg] <= 1'b1;
            t <= '0;
            ends1 <= GW'(fg);
            if (ends1 == NO_GRP) begin
              ends0 <= GW'(fg);
              state <= APPEND;
            end else begin
              lk <= ends1;
              state <= F_LINK;
            end
          end
        end
        F_LINK: state <= APPEND;
        APPEND: begin
          queued[s] <= 1'b1;
          res <= '{status: ST_OK,
                   slot_out: (op_q == OP_ATTACH) ? 6'(s) : id_q,
                   fired: 1'b0, fire_count: '0, last: 1'b1};
          state <= (t != '0) ? APP2 : RESULT;
        end
        APP2: state <= RESULT;
        RESULT: begin
          if (can_push) state <= IDLE;
        end
        // check: fire from each group head in order
        C_GRP: begin
          state <= (g == NO_GRP || cnt == MAX_FIRE) ? D_START : C_HEAD;
        end
        C_HEAD: begin
          gn <= onext_rd;
          if (head_rd == '0) begin
            g <= onext_rd;
            state <= C_GRP;
          end else begin
            s <= head_rd;
            state <= C_EXP;
          end
        end
        C_EXP: begin
          if (expired) begin
            state <= REL;
          end else begin
            g <= gn;
            state <= C_GRP;
          end
        end
        C_EMIT: begin
          if (!pend_valid || can_push) begin
            pend <= '{status: ST_OK, slot_out: 6'(s), fired: 1'b1,
                      fire_count: cnt + 6'd1, last: 1'b0};
            pend_valid <= 1'b1;
            cnt <= cnt + 6'd1;
            state <= C_GRP;
          end
        end
        // drop groups left empty
        D_START: begin
          pg <= NO_GRP;
          g <= ends0;
          state <= D_GRP;
        end
        D_GRP: state <= (g == NO_GRP) ? C_FIN : D_CHK;
        D_CHK: begin
          if (head_rd == '0) begin
            gvalid[g[GIW-1:0]] <= 1'b0;
            if (pg == NO_GRP) ends0 <= onext_rd;
            if (ends1 == g) ends1 <= pg;
          end else begin
            pg <= g;
          end
          g <= onext_rd;
          state <= D_GRP;
        end
        C_FIN: begin
          if (can_push) begin
            pend_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `GTQ_ASSERT_IMP(a_free_head_unused, free_head != '0, !in_use[free_head])
  `GTQ_ASSERT_IMP(a_queued_in_use, queued[s], in_use[s])
  `GTQ_ASSERT_IMP(a_pend_check_only, pend_valid, op_q == OP_CHECK)
  `GTQ_ASSERT_NEXT(a_cmd_taken, cmd_valid && state == IDLE, state != IDLE)
endmodule

// File: src/grouped_timer_queue_manager_unit.sv
// Timer queue manager: a pool of timer slots (slot 0 reserved) on a LIFO free list, each armed
// timer queued in the FIFO of its timeout group, groups kept in creation order. One command
// is taken at a time; cmd_stall stays high until its last result has entered the output
// register. All tables sit in single-port-read synchronous memories, so every step is a
// read followed by a modify/write in the next cycle. Attach pops the free list, then walks
// the groups in the timeout lookup and appends the timer (with one more link write when the
// group already holds timers); reattach unlinks a queued timer in place of the free-list pop,
// and detach unlinks the timer and releases its slot; check visits each group head, fires
// expired timers and then sweeps out empty groups. Results wait in the output register while
// the next command is being worked on.
module grouped_timer_queue_manager_unit #(
  parameter int TIMER_SLOTS    = 64,
  parameter int TIMEOUT_GROUPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  gtq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output gtq_pkg::rsp_t rsp
);
  import gtq_pkg::*;

  push_t push;
  logic  busy;
  logic  can_push;

  assign cmd_stall = busy;
  assign can_push  = !rsp_valid || !rsp_stall;

  gtq_ctrl #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .TIMEOUT_GROUPS(TIMEOUT_GROUPS)
  ) u_ctrl (
    .clk,
    .rst,
    .cmd_valid,
    .cmd,
    .busy,
    .can_push,
    .push
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      rsp <= push.rsp;
    end
  end
endmodule
